[sv/button_click_event_detector_core_macros.svh]
// Assertion macros for the button click event detector.
// Simulation builds get concurrent assertions; synthesis builds get empty bodies.
// Users must have clk and rst_n in scope.
`ifndef BUTTON_CLICK_EVENT_DETECTOR_CORE_MACROS_SVH
`define BUTTON_CLICK_EVENT_DETECTOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
// ante |-> cons, checked at every clk edge outside reset
`define BCED_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bced: implication check failed");
// ante |=> cons
`define BCED_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bced: next-cycle check failed");
`else
`define BCED_ASSERT_IMP(label, ante, cons)
`define BCED_ASSERT_NXT(label, ante, cons)
`endif

`endif

[sv/bced_pkg.sv]
// Shared types and constants for the button click event detector.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bced_pkg;

  localparam int unsigned MAX_EVENTS = 3;

  typedef enum logic [1:0] {
    EV_PRESS        = 2'd0,
    EV_RELEASE      = 2'd1,
    EV_LONG_PRESS   = 2'd2,
    EV_DOUBLE_CLICK = 2'd3
  } event_kind_t;

  // register index = paddr[3:2]
  localparam logic [1:0] REG_DEBOUNCE     = 2'd0;
  localparam logic [1:0] REG_LONG_PRESS   = 2'd1;
  localparam logic [1:0] REG_DOUBLE_CLICK = 2'd2;

  localparam logic [15:0] DEBOUNCE_RESET     = 16'd50;
  localparam logic [15:0] LONG_PRESS_RESET   = 16'd1000;
  localparam logic [15:0] DOUBLE_CLICK_RESET = 16'd300;

  typedef struct packed {
    logic [15:0] debounce_ticks;
    logic [15:0] long_press_ticks;
    logic [15:0] double_click_ticks;
  } cfg_t;

  typedef struct packed {
    event_kind_t kind;
    logic        switch_on;
    logic [15:0] press_total;
    logic [15:0] long_press_total;
    logic [15:0] double_click_total;
    logic        last_of_tick;
  } event_t;

  typedef struct packed {
    logic [1:0]                   count;
    event_t [MAX_EVENTS-1:0]      events;
  } tick_result_t;

endpackage

`default_nettype wire

[sv/bced_engine.sv]
// Tick evaluation: timers, debounced level, click state and counters.
// Depends on bced_pkg. Produces the event list of the presented tick.
`timescale 1ns / 1ps
`default_nettype none

module bced_engine (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   step,
  input  wire                   level,
  input  wire bced_pkg::cfg_t   cfg,
  output bced_pkg::tick_result_t result
);

  logic        prev_level_r, prev_level_nxt;
  logic        deb_pressed_r, deb_pressed_nxt;
  logic        toggle_r, toggle_nxt;
  logic        pending_r, pending_nxt;
  logic [15:0] db_rem_r, db_rem_nxt;
  logic        db_run_r, db_run_nxt;
  logic [15:0] hold_rem_r, hold_rem_nxt;
  logic        hold_run_r, hold_run_nxt;
  logic [15:0] win_rem_r, win_rem_nxt;
  logic        win_run_r, win_run_nxt;
  logic [15:0] press_cnt_r, press_cnt_nxt;
  logic [15:0] long_cnt_r, long_cnt_nxt;
  logic [15:0] dbl_cnt_r, dbl_cnt_nxt;

  logic        lvl_change;
  logic [15:0] db_rem_a;
  logic        db_run_a;
  logic        hold_exp, win_exp, db_exp;
  logic        take, take_press, take_release;
  logic        pend_after_win, is_double;
  logic        toggle_new;
  logic [15:0] press_total, long_total, dbl_total;
  logic [1:0]  n;

  function automatic bced_pkg::event_t make_event(
    input bced_pkg::event_kind_t kind,
    input logic                  sw,
    input logic [15:0]           p,
    input logic [15:0]           l,
    input logic [15:0]           d
  );
    bced_pkg::event_t e;
    e.kind               = kind;
    e.switch_on          = sw;
    e.press_total        = p;
    e.long_press_total   = l;
    e.double_click_total = d;
    e.last_of_tick       = 1'b0;
    return e;
  endfunction

  // level change reloads the debounce timer before the countdowns
  assign lvl_change = (level != prev_level_r);
  assign db_rem_a   = lvl_change ? cfg.debounce_ticks : db_rem_r;
  assign db_run_a   = lvl_change | db_run_r;

  // a count of 0 or 1 expires on this countdown
  assign hold_exp = hold_run_r & (hold_rem_r <= 16'd1);
  assign win_exp  = win_run_r & (win_rem_r <= 16'd1);
  assign db_exp   = db_run_a & (db_rem_a <= 16'd1);

  assign take         = db_exp & (level != deb_pressed_r);
  assign take_press   = take & level;
  assign take_release = take & ~level;

  // window expiry is seen before the debounced release
  assign pend_after_win = pending_r & ~win_exp;
  assign is_double      = take_release & pend_after_win;
  assign toggle_new     = toggle_r ^ take_release;

  assign press_total = press_cnt_r + {15'd0, take_press};
  assign long_total  = long_cnt_r + {15'd0, hold_exp};
  assign dbl_total   = dbl_cnt_r + {15'd0, is_double};

  always_comb begin
    prev_level_nxt  = level;
    deb_pressed_nxt = take ? level : deb_pressed_r;
    toggle_nxt      = toggle_new;
    press_cnt_nxt   = press_total;
    long_cnt_nxt    = long_total;
    dbl_cnt_nxt     = dbl_total;

    db_rem_nxt = db_exp ? 16'd0 : (db_run_a ? db_rem_a - 16'd1 : db_rem_a);
    db_run_nxt = db_run_a & ~db_exp;

    hold_rem_nxt = hold_exp ? 16'd0 : (hold_run_r ? hold_rem_r - 16'd1 : hold_rem_r);
    hold_run_nxt = hold_run_r & ~hold_exp;
    if (take_press) begin
      hold_rem_nxt = cfg.long_press_ticks;
      hold_run_nxt = 1'b1;
    end else if (take_release) begin
      hold_rem_nxt = 16'd0;
      hold_run_nxt = 1'b0;
    end

    win_rem_nxt = win_exp ? 16'd0 : (win_run_r ? win_rem_r - 16'd1 : win_rem_r);
    win_run_nxt = win_run_r & ~win_exp;
    pending_nxt = pend_after_win;
    if (take_release) begin
      if (pend_after_win) begin
        pending_nxt = 1'b0;
        win_rem_nxt = 16'd0;
        win_run_nxt = 1'b0;
      end else begin
        pending_nxt = 1'b1;
        win_rem_nxt = cfg.double_click_ticks;
        win_run_nxt = 1'b1;
      end
    end
  end

  // event list in emission order: long press, press | double click, release
  always_comb begin
    result = '0;
    n      = 2'd0;
    if (hold_exp) begin
      result.events[n] = make_event(bced_pkg::EV_LONG_PRESS, toggle_r, press_cnt_r,
                                    long_total, dbl_cnt_r);
      n = n + 2'd1;
    end
    if (take_press) begin
      result.events[n] = make_event(bced_pkg::EV_PRESS, toggle_r, press_total,
                                    long_total, dbl_cnt_r);
      n = n + 2'd1;
    end
    if (is_double) begin
      result.events[n] = make_event(bced_pkg::EV_DOUBLE_CLICK, toggle_r, press_cnt_r,
                                    long_total, dbl_total);
      n = n + 2'd1;
    end
    if (take_release) begin
      result.events[n] = make_event(bced_pkg::EV_RELEASE, toggle_new, press_cnt_r,
                                    long_total, dbl_total);
      n = n + 2'd1;
    end
    if (n != 2'd0) begin
      result.events[n - 2'd1].last_of_tick = 1'b1;
    end
    result.count = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r  <= 1'b0;
      deb_pressed_r <= 1'b0;
      toggle_r      <= 1'b0;
      pending_r     <= 1'b0;
      db_rem_r      <= 16'd0;
      db_run_r      <= 1'b0;
      hold_rem_r    <= 16'd0;
      hold_run_r    <= 1'b0;
      win_rem_r     <= 16'd0;
      win_run_r     <= 1'b0;
      press_cnt_r   <= 16'd0;
      long_cnt_r    <= 16'd0;
      dbl_cnt_r     <= 16'd0;
    end else if (step) begin
      prev_level_r  <= prev_level_nxt;
      deb_pressed_r <= deb_pressed_nxt;
      toggle_r      <= toggle_nxt;
      pending_r     <= pending_nxt;
      db_rem_r      <= db_rem_nxt;
      db_run_r      <= db_run_nxt;
      hold_rem_r    <= hold_rem_nxt;
      hold_run_r    <= hold_run_nxt;
      win_rem_r     <= win_rem_nxt;
      win_run_r     <= win_run_nxt;
      press_cnt_r   <= press_cnt_nxt;
      long_cnt_r    <= long_cnt_nxt;
      dbl_cnt_r     <= dbl_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/button_click_event_detector_core.sv]
// Button click event detector, top level: APB registers, input stage, result queue.
// Depends on bced_pkg, bced_engine and button_click_event_detector_core_macros.svh.
//
// Usage:
//   in_*   : one transaction per time tick; in_tdata[0] is the sampled button level.
//   out_*  : zero to three event transactions per tick, in order
//            long press, press or double click, release. out_tlast marks the
//            last event of a tick; a tick with no events produces nothing.
//   cfg_*  : APB writes to debounce_ticks (0x0), long_press_ticks (0x4) and
//            double_click_ticks (0x8); write only while the block is idle.
// Flow: an accepted tick lands in the input register and, once the result queue
//   is free, is evaluated into the queue; its first event is then on out_*.
// Throughput: one tick per cycle while ticks produce at most one event and
//   out_tready stays high; a tick with more than one event holds the result queue
//   until all its events drain, one per cycle through out_* while out_tready is high.
// Stall: while out_tready is low the queue holds, the input register fills,
//   and in_tready drops; nothing is lost or repeated.
// Reset (rst_n low, synchronous): registers return to 50 / 1000 / 300, all
//   timers idle, counters and switch state zero, queue and input stage empty.
`timescale 1ns / 1ps
`default_nettype none

`include "button_click_event_detector_core_macros.svh"

module button_click_event_detector_core (
  input  wire         clk,
  input  wire         rst_n,
  // input tick channel
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,    // [0] raw_level, [7:1] zero
  // event channel
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [55:0] out_tdata,   // [0] switch_on, [16:1] press_total,
                                   // [32:17] long_press_total,
                                   // [48:33] double_click_total, [55:49] zero
  output logic [1:0]  out_tuser,   // [1:0] event_kind
  output logic        out_tlast,   // last_of_tick
  // configuration
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [3:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  bced_pkg::cfg_t cfg_r;
  logic           cfg_wr;

  logic s1_valid_r;   // input stage
  logic s1_level_r;

  bced_pkg::event_t [bced_pkg::MAX_EVENTS-1:0] ev_r, ev_nxt;
  logic [1:0] cnt_r, cnt_nxt;   // events left in the queue, head at ev_r[0]

  bced_pkg::tick_result_t result;
  bced_pkg::event_t       head;

  logic out_fire;
  logic q_free;     // queue can take a new tick's events this cycle
  logic advance;    // input stage evaluated into the queue this cycle

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks     <= bced_pkg::DEBOUNCE_RESET;
      cfg_r.long_press_ticks   <= bced_pkg::LONG_PRESS_RESET;
      cfg_r.double_click_ticks <= bced_pkg::DOUBLE_CLICK_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        bced_pkg::REG_DEBOUNCE:     cfg_r.debounce_ticks     <= cfg_pwdata[15:0];
        bced_pkg::REG_LONG_PRESS:   cfg_r.long_press_ticks   <= cfg_pwdata[15:0];
        bced_pkg::REG_DOUBLE_CLICK: cfg_r.double_click_ticks <= cfg_pwdata[15:0];
        default: ;  // unmapped, ignored
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      bced_pkg::REG_DEBOUNCE:     cfg_prdata = {16'd0, cfg_r.debounce_ticks};
      bced_pkg::REG_LONG_PRESS:   cfg_prdata = {16'd0, cfg_r.long_press_ticks};
      bced_pkg::REG_DOUBLE_CLICK: cfg_prdata = {16'd0, cfg_r.double_click_ticks};
      default:                    cfg_prdata = 32'd0;
    endcase
  end

  // ---------------- handshakes ----------------
  assign out_fire  = out_tvalid & out_tready;
  // queue can take a new tick's events when empty or when its last event leaves now
  assign q_free    = (cnt_r == 2'd0) | ((cnt_r == 2'd1) & out_fire);
  assign advance   = s1_valid_r & q_free;
  assign in_tready = ~s1_valid_r | advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready & in_tvalid) begin
      s1_level_r <= in_tdata[0];
    end
  end

  // ---------------- tick evaluation ----------------
  bced_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .level  (s1_level_r),
    .cfg    (cfg_r),
    .result (result)
  );

  // ---------------- result queue ----------------
  always_comb begin
    ev_nxt  = ev_r;
    cnt_nxt = cnt_r;
    if (advance) begin
      ev_nxt  = result.events;
      cnt_nxt = result.count;
    end else if (out_fire) begin
      ev_nxt[0] = ev_r[1];
      ev_nxt[1] = ev_r[2];
      cnt_nxt   = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_r <= ev_nxt;
  end

  assign head       = ev_r[0];
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = {7'd0, head.double_click_total, head.long_press_total,
                       head.press_total, head.switch_on};
  assign out_tuser  = head.kind;
  assign out_tlast  = head.last_of_tick;

  // ---------------- checks ----------------
  // tlast sits on the queue's final entry and nowhere else
  `BCED_ASSERT_IMP(a_tlast_matches_depth, out_tvalid, out_tlast == (cnt_r == 2'd1))
  // a waiting tick is never dropped from the input stage
  `BCED_ASSERT_NXT(a_stage_holds, s1_valid_r && !advance, s1_valid_r)
  // draining the last event with nothing behind it empties the channel
  `BCED_ASSERT_NXT(a_queue_drains, out_fire && cnt_r == 2'd1 && !advance, !out_tvalid)

endmodule

`default_nettype wire

[tb/button_click_event_detector_core_tb.sv]
// Self-checking testbench for button_click_event_detector_core: ticks in, events out.
// Keeps its own timer/counter model of the detector and checks every event.
// Depends on bced_pkg and the RTL of the block.
`timescale 1ns / 1ps

module button_click_event_detector_core_tb;

  localparam int unsigned CYCLE_LIMIT     = 200_000;
  // Slack after the last tick is taken, for ticks still in the input register or queue.
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned DRAIN_LIMIT     = 5000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  // Address 0xC decodes to no register; writes there must be dropped.
  localparam logic [1:0]  REG_UNUSED      = 2'd3;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  wire         in_tready;
  logic [7:0]  in_tdata    = 8'd0;   // [0] raw_level, [7:1] zero
  wire         out_tvalid;
  logic        out_tready  = 1'b0;
  wire  [55:0] out_tdata;            // [0] switch_on, [16:1] press_total,
                                     // [32:17] long_press_total,
                                     // [48:33] double_click_total, [55:49] zero
  wire  [1:0]  out_tuser;            // [1:0] event_kind
  wire         out_tlast;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [3:0]  cfg_paddr   = 4'd0;
  logic [31:0] cfg_pwdata  = 32'd0;
  wire  [31:0] cfg_prdata;
  wire         cfg_pready;

  button_click_event_detector_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Detector model: timer settings, debounce/hold/window timers, counters
  // ---------------------------------------------------------------------------
  logic [15:0] timer_cfg [0:2];      // indexed by REG_* constants
  bit          lvl_prev;             // level seen on the previous tick
  bit          lvl_stable;           // debounced level, 1 = pressed
  bit          sw_state;             // toggles on each debounced release
  bit          click_open;           // one release seen, window still open
  logic [15:0] db_left, hold_left, win_left;
  bit          db_on, hold_on, win_on;
  logic [15:0] n_press, n_long, n_double;

  bced_pkg::event_t due_events[$];   // predicted events not yet seen on out_*
  bit          pending_levels[$];    // ticks waiting to be sent
  int unsigned ticks_queued = 0;
  int unsigned ticks_taken  = 0;

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_gap       = 0;
  int unsigned recv_gap       = 0;
  int unsigned hold_requests  = 0;
  int unsigned hold_served    = 0;
  int unsigned rx_hold_cycles = 0;
  bit          steady         = 1'b0;  // no gaps or stalls while set
  bced_pkg::event_t want;

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] exp_val);
    mismatch_count++;
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what,
             got, exp_val);
  endtask

  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bced_pkg::event_t make_event(bced_pkg::event_kind_t kind);
    bced_pkg::event_t ev;
    ev.kind               = kind;
    ev.switch_on          = sw_state;
    ev.press_total        = n_press;
    ev.long_press_total   = n_long;
    ev.double_click_total = n_double;
    ev.last_of_tick       = 1'b0;
    return ev;
  endfunction

  // One countdown step; a timer loaded with 0 or 1 expires on its first step.
  task automatic tick_timer(inout logic [15:0] left, inout bit running, output bit expired);
    expired = 1'b0;
    if (running) begin
      if (left <= 16'd1) begin
        left    = 16'd0;
        running = 1'b0;
        expired = 1'b1;
      end else begin
        left = left - 16'd1;
      end
    end
  endtask

  task automatic reset_model();
    timer_cfg[bced_pkg::REG_DEBOUNCE]     = bced_pkg::DEBOUNCE_RESET;
    timer_cfg[bced_pkg::REG_LONG_PRESS]   = bced_pkg::LONG_PRESS_RESET;
    timer_cfg[bced_pkg::REG_DOUBLE_CLICK] = bced_pkg::DOUBLE_CLICK_RESET;
    {lvl_prev, lvl_stable, sw_state, click_open} = '0;
    {db_left, hold_left, win_left} = '0;
    {db_on, hold_on, win_on} = '0;
    {n_press, n_long, n_double} = '0;
  endtask

  // Advances the model by one tick and queues the events it produces.
  task automatic predict_tick_events(input bit level);
    bced_pkg::event_t fired[$];
    bced_pkg::event_t ev;
    bit     expired;
    // any level change restarts the debounce timer
    if (level != lvl_prev) begin
      db_left = timer_cfg[bced_pkg::REG_DEBOUNCE];
      db_on   = 1'b1;
    end
    lvl_prev = level;
    // countdown order: long press, window, debounce
    tick_timer(hold_left, hold_on, expired);
    if (expired) begin
      n_long = n_long + 16'd1;
      fired.push_back(make_event(bced_pkg::EV_LONG_PRESS));
    end
    tick_timer(win_left, win_on, expired);
    if (expired) click_open = 1'b0;
    tick_timer(db_left, db_on, expired);
    // debounce expiry with the level unchanged does nothing
    if (expired && level != lvl_stable) begin
      lvl_stable = level;
      if (level) begin
        n_press   = n_press + 16'd1;
        hold_left = timer_cfg[bced_pkg::REG_LONG_PRESS];   // restarts a running hold timer
        hold_on   = 1'b1;
        fired.push_back(make_event(bced_pkg::EV_PRESS));
      end else begin
        hold_on   = 1'b0;
        hold_left = 16'd0;
        if (click_open) begin
          click_open = 1'b0;
          win_on     = 1'b0;
          win_left   = 16'd0;
          n_double   = n_double + 16'd1;
          fired.push_back(make_event(bced_pkg::EV_DOUBLE_CLICK));  // pre-toggle state
        end else begin
          click_open = 1'b1;
          win_left   = timer_cfg[bced_pkg::REG_DOUBLE_CLICK];
          win_on     = 1'b1;
        end
        sw_state = ~sw_state;
        fired.push_back(make_event(bced_pkg::EV_RELEASE));
      end
    end
    foreach (fired[i]) begin
      ev = fired[i];
      ev.last_of_tick = (i == fired.size() - 1);
      due_events.push_back(ev);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tick driver: one transaction per queued level, random gaps between them
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_tick_events(in_tdata[0]);
        ticks_taken++;
      end
      // valid stays up until taken, so only touch it when the slot is free
      if (!in_tvalid || in_tready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_levels.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= {7'd0, pending_levels.pop_front()};
          send_gap  = idle_len();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Event monitor: checks each transaction against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_events.size() == 0) begin
          report_mismatch("event with none due", {14'd0, out_tuser}, 16'd0);
        end else begin
          want = due_events.pop_front();
          if (out_tuser !== want.kind)
            report_mismatch("event_kind", {14'd0, out_tuser}, 16'(want.kind));
          if (out_tdata[0] !== want.switch_on)
            report_mismatch("switch_on", {15'd0, out_tdata[0]}, {15'd0, want.switch_on});
          if (out_tdata[16:1] !== want.press_total)
            report_mismatch("press_total", out_tdata[16:1], want.press_total);
          if (out_tdata[32:17] !== want.long_press_total)
            report_mismatch("long_press_total", out_tdata[32:17], want.long_press_total);
          if (out_tdata[48:33] !== want.double_click_total)
            report_mismatch("double_click_total", out_tdata[48:33],
                            want.double_click_total);
          if (out_tlast !== want.last_of_tick)
            report_mismatch("last_of_tick", {15'd0, out_tlast}, {15'd0, want.last_of_tick});
        end
      end
      if (rx_hold_cycles != 0) begin
        out_tready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        recv_gap = idle_len();
      end
    end
  end

  // Long receiver hold-off; the sender keeps offering, so in_tready must drop.
  always @(posedge clk) begin
    if (rx_hold_cycles != 0) begin
      rx_hold_cycles <= rx_hold_cycles - 1;
    end else if (hold_served != hold_requests) begin
      hold_served    <= hold_requests;
      rx_hold_cycles <= HOLD_OFF_CYCLES;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_level(input bit level);
    pending_levels.push_back(level);
    ticks_queued++;
  endtask

  // Every tick taken, every event drained, plus slack for ticks still in flight
  // that produce nothing.
  task automatic wait_idle();
    while (ticks_taken != ticks_queued || due_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_cycle(input bit wr, input logic [1:0] idx, input logic [31:0] wdata,
                           output logic [31:0] rdata);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    logic [31:0] noise;
    logic [31:0] unused;
    noise = $urandom;
    // upper half is don't-care for 16-bit registers, so keep it busy
    apb_cycle(1'b1, idx, {noise[31:16], value}, unused);
    if (idx != REG_UNUSED) timer_cfg[idx] = value;
  endtask

  task automatic check_regs();
    logic [31:0] got;
    logic [1:0]  idx;
    for (int i = 0; i < 3; i++) begin
      idx = 2'(i);
      apb_cycle(1'b0, idx, 32'd0, got);
      if (got !== {16'd0, timer_cfg[idx]})
        report_mismatch("register readback", got[15:0], timer_cfg[idx]);
    end
  endtask

  task automatic set_timers(input logic [15:0] db, input logic [15:0] hold,
                            input logic [15:0] win);
    write_reg(bced_pkg::REG_DEBOUNCE, db);
    write_reg(bced_pkg::REG_LONG_PRESS, hold);
    write_reg(bced_pkg::REG_DOUBLE_CLICK, win);
    check_regs();
  endtask

  // mostly short timers so gestures finish quickly; 0 and 1 now and then
  function automatic logic [15:0] pick_length(input int unsigned top);
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return 16'd0;
    if (roll < 4) return 16'd1;
    return 16'($urandom_range(1, top));
  endfunction

  // Mostly press/release gestures with contact bounce, some raw noise.
  task automatic queue_random_ticks(input int unsigned count);
    int unsigned added, span, reach, j, k;
    bit          lvl;
    added = 0;
    while (added < count) begin
      if ($urandom_range(0, 4) == 0) begin
        span = $urandom_range(1, 6);
        for (j = 0; j < span; j++) queue_level(1'($urandom_range(0, 1)));
        added += span;
      end else begin
        for (k = 0; k < 2; k++) begin
          lvl  = (k == 0);
          span = $urandom_range(0, 3);
          for (j = 0; j < span; j++) queue_level(1'($urandom_range(0, 1)));
          added += span;
          // hold long enough to reach the long press / window expiry sometimes
          reach = timer_cfg[bced_pkg::REG_DEBOUNCE] + 3 +
                  (lvl ? timer_cfg[bced_pkg::REG_LONG_PRESS] :
                         timer_cfg[bced_pkg::REG_DOUBLE_CLICK]);
          if (reach > 40) reach = 40;
          span = $urandom_range(1, reach);
          for (j = 0; j < span; j++) queue_level(lvl);
          added += span;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned drain_wait;
    reset_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values, then two ticks under them (debounce 50: nothing fires)
    check_regs();
    queue_level(1'b1);
    queue_level(1'b0);
    wait_idle();

    // zero debounce acts as one: edges are taken on the tick they appear.
    // Covers press, long press, release, double click, and a single tick
    // with long press + double click + release.
    set_timers(16'd0, 16'd2, 16'd4);
    write_reg(REG_UNUSED, 16'hBEEF);
    check_regs();
    queue_level(1'b1); queue_level(1'b1); queue_level(1'b1); queue_level(1'b0);
    queue_level(1'b1); queue_level(1'b0); queue_level(1'b1); queue_level(1'b0);
    queue_level(1'b1); queue_level(1'b1); queue_level(1'b0);
    wait_idle();

    // bounce that settles back on the debounced level, zero long-press and
    // window lengths, window expiry right after a release
    set_timers(16'd3, 16'd0, 16'd0);
    queue_level(1'b1); queue_level(1'b0); queue_level(1'b0); queue_level(1'b0);
    queue_level(1'b1); queue_level(1'b1); queue_level(1'b1); queue_level(1'b1);
    queue_level(1'b0); queue_level(1'b0); queue_level(1'b0); queue_level(1'b0);
    wait_idle();

    // largest settings: the debounce timer loads but never expires in this short stretch
    set_timers(16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 8; i++) queue_level(1'($urandom_range(0, 1)));
    wait_idle();

    // smallest nonzero settings; running timers keep their old counts
    set_timers(16'd1, 16'd1, 16'd1);
    queue_random_ticks(20);
    wait_idle();

    // random phases: one without any gaps, one with a long receiver hold-off
    for (int phase = 0; phase < 4; phase++) begin
      set_timers(pick_length(4), pick_length(20), pick_length(20));
      steady = (phase == 0);
      queue_random_ticks(25);
      if (phase == 1) hold_requests++;
      wait_idle();
    end

    // drain; anything still due after that is a missing event
    while (ticks_taken != ticks_queued) @(posedge clk);
    drain_wait = 0;
    while (due_events.size() != 0 && drain_wait < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (due_events.size() != 0)
      report_mismatch("events never delivered", 16'(due_events.size()), 16'd0);

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[button_click_event_detector_core.f]
+incdir+sv
sv/bced_pkg.sv
sv/bced_engine.sv
sv/button_click_event_detector_core.sv
tb/button_click_event_detector_core_tb.sv
